### rtl/psx_pad_frame_to_hid_report_assert.svh
// assertion macros for the controller poll to gamepad report converter
`ifndef PSX_PAD_FRAME_TO_HID_REPORT_ASSERT_SVH
`define PSX_PAD_FRAME_TO_HID_REPORT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSX_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psx frame converter: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PSX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psx frame converter: next-cycle check failed");

`endif

### rtl/psxhid_pkg.sv
// shared types, constants and report mapping for the controller poll converter
`default_nettype none

package psxhid_pkg;

	// one exchanged byte pair of a poll
	typedef struct packed {
		logic [7:0] command_byte;
		logic [7:0] reply_byte;
		logic       ack_seen;
	} pad_req_t;

	// frame outcome codes
	typedef enum logic [1:0] {
		ST_UPDATED   = 2'd0,
		ST_NO_UPDATE = 2'd1,
		ST_ABORTED   = 2'd2
	} frame_status_t;

	// one gamepad report
	typedef struct packed {
		frame_status_t frame_status;
		logic          newly_connected;
		logic [3:0]    device_id;
		logic [3:0]    hat_code;
		logic [9:0]    button_bits;
		logic [7:0]    left_x;
		logic [7:0]    left_y;
		logic [7:0]    right_x;
		logic [7:0]    right_y;
		logic [7:0]    l2_level;
		logic [7:0]    r2_level;
	} hid_rpt_t;

	localparam logic [3:0]  ID_NONE      = 4'hF;
	localparam logic [7:0]  MODE_READ    = 8'h42;
	localparam logic [7:0]  MODE_CONFIG  = 8'h43;
	localparam logic [7:0]  REPLY_CFG    = 8'hF3;
	localparam logic [7:0]  STORE_RESET  = 8'hFF;
	localparam logic [7:0]  STICK_CENTER = 8'h80;
	localparam logic [7:0]  TRIG_FULL    = 8'hFF;
	localparam logic [15:0] BTN_RELEASED = 16'hFFFF;
	localparam logic [3:0]  HAT_CENTER   = 4'd8;
	localparam int unsigned START_LEN    = 5;

	// active-low bit positions in the stored button word
	localparam int unsigned B_L2  = 0;
	localparam int unsigned B_R2  = 1;
	localparam int unsigned B_L1  = 2;
	localparam int unsigned B_R1  = 3;
	localparam int unsigned B_TRI = 4;
	localparam int unsigned B_CIR = 5;
	localparam int unsigned B_CRO = 6;
	localparam int unsigned B_SQU = 7;
	localparam int unsigned B_SEL = 8;
	localparam int unsigned B_L3  = 9;
	localparam int unsigned B_R3  = 10;
	localparam int unsigned B_STA = 11;
	localparam int unsigned B_UP  = 12;
	localparam int unsigned B_RT  = 13;
	localparam int unsigned B_DN  = 14;
	localparam int unsigned B_LT  = 15;

	// d-pad to hat direction, opposing presses cancel
	function automatic logic [3:0] hat_of(input logic [15:0] btn);
		logic u, r, d, l, ro, lo;
		logic [3:0] h;
		u  = ~btn[B_UP];
		r  = ~btn[B_RT];
		d  = ~btn[B_DN];
		l  = ~btn[B_LT];
		ro = r & ~l;
		lo = l & ~r;
		if (u && !d) begin
			h = ro ? 4'd1 : (lo ? 4'd7 : 4'd0);
		end else if (d && !u) begin
			h = ro ? 4'd3 : (lo ? 4'd5 : 4'd4);
		end else if (ro) begin
			h = 4'd2;
		end else if (lo) begin
			h = 4'd6;
		end else begin
			h = HAT_CENTER;
		end
		return h;
	endfunction

	// remap active-low pad buttons into active-high report order
	function automatic logic [9:0] map_buttons(input logic [15:0] btn);
		logic [9:0] b;
		b[0] = ~btn[B_CRO];
		b[1] = ~btn[B_CIR];
		b[2] = ~btn[B_SQU];
		b[3] = ~btn[B_TRI];
		b[4] = ~btn[B_L1];
		b[5] = ~btn[B_R1];
		b[6] = ~btn[B_SEL];
		b[7] = ~btn[B_STA];
		b[8] = ~btn[B_L3];
		b[9] = ~btn[B_R3];
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/psx_pad_frame_to_hid_report.sv
// controller poll byte stream to gamepad report converter, top level
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------
//  pad     | in  | pad_valid/pad_stall | psxhid_pkg::pad_req_t
//  hid     | out | hid_valid/hid_stall | psxhid_pkg::hid_rpt_t
//
// one request per cycle while pad_stall is low; a request that ends a frame passes the
// input register, then the frame logic, into the result register
// reset returns position, length, stored id, buttons, sticks and reply bytes to start values
// the input register holds a request only while a result waits in the
// result register; requests that end no frame pass through regardless
`default_nettype none

module psx_pad_frame_to_hid_report #(
	parameter int unsigned MAX_FRAME_BYTES = 21
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        pad_valid,
	output logic                       pad_stall,
	input  wire psxhid_pkg::pad_req_t  pad_req,
	output logic                       hid_valid,
	input  wire                        hid_stall,
	output psxhid_pkg::hid_rpt_t       hid_rpt
);

	localparam int unsigned FB_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [5:0]  MAX_W6 = 6'(MAX_FRAME_BYTES);

	// input register
	logic                  valid_s1;
	psxhid_pkg::pad_req_t  req_s1;

	// frame state
	logic [FB_W-1:0] pos_q;
	logic [FB_W-1:0] fb_q;
	logic [7:0]      mode_q;
	logic [7:0]      r1_q;
	logic [7:0]      store_q [6];	// reply bytes 3 to 8
	logic [3:0]      id_q;
	logic [15:0]     btn_q;
	logic [7:0]      stick_q [4];	// right x, right y, left x, left y

	// result register
	logic                  out_valid_q;
	psxhid_pkg::hid_rpt_t  out_q;

	// combinational frame logic
	logic [5:0]      len6;
	logic [FB_W-1:0] len_cap;
	logic [FB_W-1:0] fb_eff;
	logic [FB_W-1:0] pos_inc;
	logic            at_end;
	logic            emits;
	logic            out_free;
	logic            s1_go;
	logic            do_upd;
	logic [7:0]      cur_byte [6];
	logic [3:0]      id_n;
	logic [15:0]     btn_n;
	logic [7:0]      stick_n [4];
	logic            out_aborted;
	psxhid_pkg::hid_rpt_t rpt_n;

	// frame length from reply byte 1
	always_comb begin
		len6    = {1'b0, req_s1.reply_byte[3:0], 1'b0} + 6'd3;
		len_cap = (len6 > MAX_W6) ? FB_W'(MAX_FRAME_BYTES) : FB_W'(len6);
		fb_eff  = (pos_q == FB_W'(1)) ? len_cap : fb_q;
		pos_inc = pos_q + FB_W'(1);
		at_end  = (pos_inc == fb_eff);
		emits   = at_end || !req_s1.ack_seen;
	end

	// flow control
	assign out_free  = !out_valid_q || !hid_stall;
	assign s1_go     = valid_s1 && (!emits || out_free);
	assign pad_stall = valid_s1 && !s1_go;

	// next state at a completed frame
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			cur_byte[i] = (pos_q == FB_W'(i + 3)) ? req_s1.reply_byte : store_q[i];
		end
		do_upd = at_end && (mode_q == psxhid_pkg::MODE_READ ||
			mode_q == psxhid_pkg::MODE_CONFIG) && (r1_q != psxhid_pkg::REPLY_CFG);
		id_n  = do_upd ? r1_q[7:4] : id_q;
		btn_n = do_upd ? {cur_byte[0], cur_byte[1]} : btn_q;
		for (int i = 0; i < 4; i++) begin
			stick_n[i] = (do_upd && (FB_W'(i + 5) < fb_q)) ? cur_byte[i + 2] : stick_q[i];
		end
	end

	// report built from the post-update state
	always_comb begin
		rpt_n = '0;
		if (!at_end) begin
			rpt_n.frame_status = psxhid_pkg::ST_ABORTED;
		end else if (do_upd) begin
			rpt_n.frame_status = psxhid_pkg::ST_UPDATED;
		end else begin
			rpt_n.frame_status = psxhid_pkg::ST_NO_UPDATE;
		end
		rpt_n.newly_connected = do_upd && (id_q == psxhid_pkg::ID_NONE) &&
			(id_n != psxhid_pkg::ID_NONE);
		rpt_n.device_id = id_n;
		if (id_n == psxhid_pkg::ID_NONE) begin
			rpt_n.hat_code    = psxhid_pkg::HAT_CENTER;
			rpt_n.button_bits = '0;
			rpt_n.left_x      = psxhid_pkg::STICK_CENTER;
			rpt_n.left_y      = psxhid_pkg::STICK_CENTER;
			rpt_n.right_x     = psxhid_pkg::STICK_CENTER;
			rpt_n.right_y     = psxhid_pkg::STICK_CENTER;
			rpt_n.l2_level    = '0;
			rpt_n.r2_level    = '0;
		end else begin
			rpt_n.hat_code    = psxhid_pkg::hat_of(btn_n);
			rpt_n.button_bits = psxhid_pkg::map_buttons(btn_n);
			rpt_n.left_x      = stick_n[2];
			rpt_n.left_y      = stick_n[3];
			rpt_n.right_x     = stick_n[0];
			rpt_n.right_y     = stick_n[1];
			rpt_n.l2_level    = btn_n[psxhid_pkg::B_L2] ? 8'h00 : psxhid_pkg::TRIG_FULL;
			rpt_n.r2_level    = btn_n[psxhid_pkg::B_R2] ? 8'h00 : psxhid_pkg::TRIG_FULL;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pad_stall) begin
			valid_s1 <= pad_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (!pad_stall && pad_valid) begin
			req_s1 <= pad_req;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fb_q   <= FB_W'(psxhid_pkg::START_LEN);
			mode_q <= '0;
			r1_q   <= psxhid_pkg::STORE_RESET;
			id_q   <= psxhid_pkg::ID_NONE;
			btn_q  <= psxhid_pkg::BTN_RELEASED;
			for (int i = 0; i < 6; i++) begin
				store_q[i] <= psxhid_pkg::STORE_RESET;
			end
			for (int i = 0; i < 4; i++) begin
				stick_q[i] <= psxhid_pkg::STICK_CENTER;
			end
		end else if (s1_go) begin
			if (pos_q == FB_W'(1)) begin
				r1_q   <= req_s1.reply_byte;
				mode_q <= req_s1.command_byte;
			end
			for (int i = 0; i < 6; i++) begin
				store_q[i] <= cur_byte[i];
			end
			id_q  <= id_n;
			btn_q <= btn_n;
			for (int i = 0; i < 4; i++) begin
				stick_q[i] <= stick_n[i];
			end
			if (emits) begin
				pos_q <= '0;
				fb_q  <= FB_W'(psxhid_pkg::START_LEN);
			end else begin
				pos_q <= pos_inc;
				fb_q  <= fb_eff;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emits) begin
			out_valid_q <= 1'b1;
		end else if (!hid_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_go && emits) begin
			out_q <= rpt_n;
		end
	end

	assign hid_valid = out_valid_q;
	assign hid_rpt   = out_q;

	// aborted report on the output
	assign out_aborted = out_valid_q && (out_q.frame_status == psxhid_pkg::ST_ABORTED);

	`include "psx_pad_frame_to_hid_report_assert.svh"

	`PSX_ASSERT_NOW(a_pos_in_frame, 1'b1, pos_q < fb_q)
	`PSX_ASSERT_NOW(a_len_capped, 1'b1, fb_q <= FB_W'(MAX_FRAME_BYTES))
	`PSX_ASSERT_NOW(a_abort_not_new, out_aborted, !out_q.newly_connected)
	`PSX_ASSERT_NEXT(a_result_loaded, s1_go && emits, out_valid_q)

endmodule

`default_nettype wire
